// ===== design/pmg_pkg.sv =====
`default_nettype none

package pmg_pkg;

    localparam int FLD_W    = 48;
    localparam int MU_W     = 48;
    localparam int OUT_W    = 48;
    localparam int VEC_W    = FLD_W + 1;
    localparam int MAG_W    = FLD_W;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int FRAC_W   = 32;
    localparam int ROOT_X_W = SUM_W + FRAC_W;
    localparam int ROOT_W   = ROOT_X_W / 2;
    localparam int DEN_W    = SUM_W + ROOT_W;
    localparam int NUM_P_W  = MU_W + MAG_W;
    localparam int NUM_SH   = 68;
    localparam int NUM_W    = NUM_P_W + NUM_SH;
    localparam int QUO_W    = 101;
    localparam int SGN_W    = QUO_W + 1;
    localparam int DIF_W    = QUO_W + 2;

    localparam logic [MU_W-1:0] MU_RESET = 48'd102041713;

    localparam int LAT_SQ   = ((MAG_W + 31) / 32) * ((MAG_W + 31) / 32);
    localparam int LAT_DEN  = ((SUM_W + 31) / 32) * ((ROOT_W + 31) / 32);
    localparam int LAT_NUM  = ((MU_W + 31) / 32) * ((MAG_W + 31) / 32);
    localparam int LAT_ROOT = ROOT_W;
    localparam int LAT_DIV  = QUO_W;
    localparam int DLY_MAG  = LAT_SQ + 1 + LAT_ROOT + LAT_DEN - LAT_NUM;
    localparam int DLY_SIGN = LAT_SQ + 1 + LAT_ROOT + LAT_DEN + LAT_DIV;
    localparam int LAT_TERM = 1 + DLY_SIGN;
    localparam int LAT_ALL  = LAT_TERM + 3;

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic signed [SGN_W-1:0] t_sgn;
    typedef logic signed [DIF_W-1:0] t_dif;

endpackage

`default_nettype wire

// ===== design/pmg_if.sv =====
`default_nettype none

interface pmg_in_if;
    logic                             valid;
    logic                             ready;
    logic                             mode;
    logic signed [pmg_pkg::FLD_W-1:0] body_x;
    logic signed [pmg_pkg::FLD_W-1:0] body_y;
    logic signed [pmg_pkg::FLD_W-1:0] body_z;
    logic signed [pmg_pkg::FLD_W-1:0] sat_px;
    logic signed [pmg_pkg::FLD_W-1:0] sat_py;
    logic signed [pmg_pkg::FLD_W-1:0] sat_pz;
    logic signed [pmg_pkg::FLD_W-1:0] sat_vx;
    logic signed [pmg_pkg::FLD_W-1:0] sat_vy;
    logic signed [pmg_pkg::FLD_W-1:0] sat_vz;
    logic                             last_in;

    modport source (output valid, mode, body_x, body_y, body_z, sat_px, sat_py, sat_pz,
                    sat_vx, sat_vy, sat_vz, last_in, input ready);
    modport sink (input valid, mode, body_x, body_y, body_z, sat_px, sat_py, sat_pz,
                  sat_vx, sat_vy, sat_vz, last_in, output ready);
endinterface

interface pmg_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [pmg_pkg::OUT_W-1:0] out_a;
    logic signed [pmg_pkg::OUT_W-1:0] out_b;
    logic signed [pmg_pkg::OUT_W-1:0] out_c;
    logic signed [pmg_pkg::OUT_W-1:0] out_d;
    logic signed [pmg_pkg::OUT_W-1:0] out_e;
    logic signed [pmg_pkg::OUT_W-1:0] out_f;
    logic                             saturated;
    logic                             last_out;

    modport source (output valid, out_a, out_b, out_c, out_d, out_e, out_f, saturated,
                    last_out, input ready);
    modport sink (input valid, out_a, out_b, out_c, out_d, out_e, out_f, saturated,
                  last_out, output ready);
endinterface

`default_nettype wire

// ===== design/pmg_dly.sv =====
`default_nettype none

module pmg_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_d,
    output logic      [W-1:0] o_d
);

    logic [W-1:0] r_sh [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    assign o_d = r_sh[N-1];

endmodule

`default_nettype wire

// ===== design/pmg_mul.sv =====
`default_nettype none

// unsigned product, one 32x32 partial product accumulated per stage
module pmg_mul #(
    parameter int WA = 48,
    parameter int WB = 48
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [WA-1:0]      i_a,
    input  wire logic [WB-1:0]      i_b,
    output logic      [WA+WB-1:0]   o_p
);

    localparam int NA  = (WA + 31) / 32;
    localparam int NB  = (WB + 31) / 32;
    localparam int NS  = NA * NB;
    localparam int PAW = NA * 32;
    localparam int PBW = NB * 32;
    localparam int PW  = WA + WB;

    logic [PAW-1:0] r_a [NS];
    logic [PBW-1:0] r_b [NS];
    logic [PW-1:0]  r_p [NS];

    for (genvar k = 0; k < NS; k++) begin : g_st
        localparam int IA = k / NB;
        localparam int IB = k % NB;
        logic [PAW-1:0] a_in;
        logic [PBW-1:0] b_in;
        logic [PW-1:0]  p_in;
        logic [63:0]    pp;
        logic [PW-1:0]  n_p;

        if (k == 0) begin : g_first
            assign a_in = PAW'(i_a);
            assign b_in = PBW'(i_b);
            assign p_in = '0;
        end else begin : g_next
            assign a_in = r_a[k-1];
            assign b_in = r_b[k-1];
            assign p_in = r_p[k-1];
        end

        assign pp  = 64'(a_in[IA*32 +: 32]) * 64'(b_in[IB*32 +: 32]);
        assign n_p = p_in + (PW'(pp) << (32 * (IA + IB)));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k] <= a_in;
                r_b[k] <= b_in;
                r_p[k] <= n_p;
            end
        end
    end

    assign o_p = r_p[NS-1];

endmodule

`default_nettype wire

// ===== design/pmg_sqrt.sv =====
`default_nettype none

// floor square root, one root bit per stage
module pmg_sqrt #(
    parameter int XW = 130
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [XW-1:0]     i_x,
    output logic      [XW/2-1:0]   o_root
);

    localparam int RW = XW / 2;

    logic [XW-1:0] r_x    [RW];
    logic [RW:0]   r_rem  [RW];
    logic [RW-1:0] r_root [RW];

    for (genvar k = 0; k < RW; k++) begin : g_st
        logic [XW-1:0] x_in;
        logic [RW:0]   rem_in;
        logic [RW-1:0] root_in;
        logic [RW+2:0] rem2;
        logic [RW+2:0] trial;
        logic          ge;
        logic [RW:0]   n_rem;

        if (k == 0) begin : g_first
            assign x_in    = i_x;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign x_in    = r_x[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        assign rem2  = {rem_in, x_in[XW-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = rem2 >= trial;
        assign n_rem = ge ? (RW+1)'(rem2 - trial) : (RW+1)'(rem2);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= x_in << 2;
                r_rem[k]  <= n_rem;
                r_root[k] <= {root_in[RW-2:0], ge};
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

`default_nettype wire

// ===== design/pmg_div.sv =====
`default_nettype none

// restoring division, one quotient bit per stage; quotient known to fit QW bits
module pmg_div #(
    parameter int NUMW = 164,
    parameter int DW   = 163,
    parameter int QW   = 101
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [NUMW-1:0] i_num,
    input  wire logic [DW-1:0]   i_den,
    output logic      [QW-1:0]   o_q
);

    logic [DW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_lo  [QW];
    logic [QW-1:0] r_q   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_st
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] lo_in;
        logic [QW-1:0] q_in;
        logic [DW:0]   rem2;
        logic          ge;
        logic [DW-1:0] n_rem;

        if (k == 0) begin : g_first
            // bits above the quotient range never exceed the divisor
            assign rem_in = DW'(i_num[NUMW-1:QW]);
            assign den_in = i_den;
            assign lo_in  = i_num[QW-1:0];
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign lo_in  = r_lo[k-1];
            assign q_in   = r_q[k-1];
        end

        assign rem2  = {rem_in, lo_in[QW-1]};
        assign ge    = rem2 >= {1'b0, den_in};
        assign n_rem = ge ? DW'(rem2 - {1'b0, den_in}) : DW'(rem2);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= den_in;
                r_lo[k]  <= lo_in << 1;
                r_q[k]   <= {q_in[QW-2:0], ge};
            end
        end
    end

    assign o_q = r_q[QW-1];

endmodule

`default_nettype wire

// ===== design/pmg_term.sv =====
`default_nettype none

// mu*|v_c|*2^68 / (S*T) per component, magnitude and sign
module pmg_term (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [pmg_pkg::MU_W-1:0]    i_mu,
    input  wire pmg_pkg::t_vec               i_v [3],
    output logic      [pmg_pkg::QUO_W-1:0]   o_mag [3],
    output logic      [2:0]                  o_neg,
    output logic                             o_zero
);

    logic [pmg_pkg::MAG_W-1:0]    r_mag [3];
    logic [2:0]                   r_neg;
    logic                         r_zero;
    logic [pmg_pkg::SQ_W-1:0]     w_sq [3];
    logic [pmg_pkg::SUM_W-1:0]    r_sum;
    logic [pmg_pkg::SUM_W-1:0]    w_sum_d;
    logic [pmg_pkg::ROOT_W-1:0]   w_root;
    logic [pmg_pkg::DEN_W-1:0]    w_den;
    logic [3*pmg_pkg::MAG_W-1:0]  w_mag_d;
    logic [pmg_pkg::NUM_P_W-1:0]  w_p [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_neg[c] <= i_v[c][pmg_pkg::VEC_W-1];
                r_mag[c] <= pmg_pkg::MAG_W'(i_v[c][pmg_pkg::VEC_W-1] ? -i_v[c] : i_v[c]);
            end
            r_zero <= (i_v[0] == '0) && (i_v[1] == '0) && (i_v[2] == '0);
            r_sum  <= pmg_pkg::SUM_W'(w_sq[0]) + pmg_pkg::SUM_W'(w_sq[1])
                    + pmg_pkg::SUM_W'(w_sq[2]);
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_sq
        pmg_mul #(.WA(pmg_pkg::MAG_W), .WB(pmg_pkg::MAG_W)) u_sq (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (r_mag[c]),
            .i_b   (r_mag[c]),
            .o_p   (w_sq[c])
        );
    end

    // |v| with 16 fraction bits
    pmg_sqrt #(.XW(pmg_pkg::ROOT_X_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_x    ({r_sum, {pmg_pkg::FRAC_W{1'b0}}}),
        .o_root (w_root)
    );

    pmg_dly #(.W(pmg_pkg::SUM_W), .N(pmg_pkg::LAT_ROOT)) u_sum_dly (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (r_sum),
        .o_d   (w_sum_d)
    );

    pmg_mul #(.WA(pmg_pkg::SUM_W), .WB(pmg_pkg::ROOT_W)) u_den (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_sum_d),
        .i_b   (w_root),
        .o_p   (w_den)
    );

    // numerator timed to land together with the denominator
    pmg_dly #(.W(3*pmg_pkg::MAG_W), .N(pmg_pkg::DLY_MAG)) u_mag_dly (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   ({r_mag[2], r_mag[1], r_mag[0]}),
        .o_d   (w_mag_d)
    );

    for (genvar c = 0; c < 3; c++) begin : g_cmp
        pmg_mul #(.WA(pmg_pkg::MU_W), .WB(pmg_pkg::MAG_W)) u_num (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (i_mu),
            .i_b   (w_mag_d[c*pmg_pkg::MAG_W +: pmg_pkg::MAG_W]),
            .o_p   (w_p[c])
        );

        pmg_div #(.NUMW(pmg_pkg::NUM_W), .DW(pmg_pkg::DEN_W), .QW(pmg_pkg::QUO_W)) u_div (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_num ({w_p[c], {pmg_pkg::NUM_SH{1'b0}}}),
            .i_den (w_den),
            .o_q   (o_mag[c])
        );
    end

    pmg_dly #(.W(4), .N(pmg_pkg::DLY_SIGN)) u_sign_dly (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   ({r_zero, r_neg}),
        .o_d   ({o_zero, o_neg})
    );

endmodule

`default_nettype wire

// ===== design/point_mass_gravity_derivative_top.sv =====
// point-mass gravity derivative with indirect term, one spacecraft per request
// i_in: sink channel, valid/ready, carries mode, body and spacecraft state
// o_out: source channel, valid/ready, carries six 48-bit results, flag, last
// i_cfg_we/i_cfg_wdata: mu write on any edge with i_cfg_we high, not in reset
// pipeline: input stage, vector term (squares, 65-stage root, 12-stage
//   S*T product, 101-stage quotient), sign stage, output stage
// throughput: one request per cycle unless a held result is stalled;
//   every stage is a flop with enable
// a zero body vector drops the indirect term; a zero distance gives zero
// acceleration with the saturated flag set
// reset clears all valid bits and loads mu with its default
// when the receiver stalls a held result, the whole pipeline freezes and
// i_in.ready drops in the same cycle; nothing is lost or duplicated
`default_nettype none

module point_mass_gravity_derivative_top (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    pmg_in_if.sink                        i_in,
    pmg_out_if.source                     o_out,
    input  wire logic                     i_cfg_we,
    input  wire logic [pmg_pkg::MU_W-1:0] i_cfg_wdata
);

    localparam int SB_W = 3 * pmg_pkg::FLD_W + 2;

    logic                         w_adv;
    logic [pmg_pkg::MU_W-1:0]     r_mu;
    logic [pmg_pkg::LAT_ALL-1:0]  r_vld;
    pmg_pkg::t_vec                r_d [3];
    pmg_pkg::t_vec                r_b [3];
    logic [pmg_pkg::QUO_W-1:0]    w_dm [3];
    logic [pmg_pkg::QUO_W-1:0]    w_bm [3];
    logic [2:0]                   w_dn;
    logic [2:0]                   w_bn;
    logic                         w_dz;
    logic                         w_bz;
    logic [SB_W-1:0]              w_sb;
    pmg_pkg::t_sgn                r_sd [3];
    pmg_pkg::t_sgn                r_si [3];
    logic                         r_dz;
    pmg_pkg::t_dif                w_dif [3];
    logic [pmg_pkg::OUT_W-1:0]    n_acc [3];
    logic                         n_flag;
    logic                         w_mode;
    logic [pmg_pkg::OUT_W-1:0]    w_vel [3];
    logic                         w_last;
    logic [pmg_pkg::OUT_W-1:0]    r_out [6];
    logic                         r_sat;
    logic                         r_last;

    assign w_adv      = !o_out.valid || o_out.ready;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu <= pmg_pkg::MU_RESET;
        end else if (i_cfg_we) begin
            r_mu <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[pmg_pkg::LAT_ALL-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b[0] <= pmg_pkg::t_vec'(i_in.body_x);
            r_b[1] <= pmg_pkg::t_vec'(i_in.body_y);
            r_b[2] <= pmg_pkg::t_vec'(i_in.body_z);
            r_d[0] <= pmg_pkg::t_vec'(i_in.body_x) - pmg_pkg::t_vec'(i_in.sat_px);
            r_d[1] <= pmg_pkg::t_vec'(i_in.body_y) - pmg_pkg::t_vec'(i_in.sat_py);
            r_d[2] <= pmg_pkg::t_vec'(i_in.body_z) - pmg_pkg::t_vec'(i_in.sat_pz);
        end
    end

    pmg_term u_term_d (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_mu   (r_mu),
        .i_v    (r_d),
        .o_mag  (w_dm),
        .o_neg  (w_dn),
        .o_zero (w_dz)
    );

    pmg_term u_term_b (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_mu   (r_mu),
        .i_v    (r_b),
        .o_mag  (w_bm),
        .o_neg  (w_bn),
        .o_zero (w_bz)
    );

    pmg_dly #(.W(SB_W), .N(pmg_pkg::LAT_ALL - 1)) u_sb_dly (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   ({i_in.mode, i_in.sat_vz, i_in.sat_vy, i_in.sat_vx, i_in.last_in}),
        .o_d   (w_sb)
    );

    assign w_mode   = w_sb[SB_W-1];
    assign w_vel[2] = w_sb[1 + 2*pmg_pkg::FLD_W +: pmg_pkg::FLD_W];
    assign w_vel[1] = w_sb[1 + pmg_pkg::FLD_W +: pmg_pkg::FLD_W];
    assign w_vel[0] = w_sb[1 +: pmg_pkg::FLD_W];
    assign w_last   = w_sb[0];

    // apply signs; indirect term drops out for a zero body vector
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < 3; c++) begin
                r_sd[c] <= w_dn[c] ? -pmg_pkg::t_sgn'({1'b0, w_dm[c]})
                                   :  pmg_pkg::t_sgn'({1'b0, w_dm[c]});
                if (w_bz) begin
                    r_si[c] <= '0;
                end else begin
                    r_si[c] <= w_bn[c] ? -pmg_pkg::t_sgn'({1'b0, w_bm[c]})
                                       :  pmg_pkg::t_sgn'({1'b0, w_bm[c]});
                end
            end
            r_dz <= w_dz;
        end
    end

    always_comb begin
        n_flag = r_dz;
        for (int c = 0; c < 3; c++) begin
            w_dif[c] = pmg_pkg::t_dif'(r_sd[c]) - pmg_pkg::t_dif'(r_si[c]);
            if (r_dz) begin
                n_acc[c] = '0;
            end else if (!w_dif[c][pmg_pkg::DIF_W-1]
                         && (|w_dif[c][pmg_pkg::DIF_W-2:pmg_pkg::OUT_W-1])) begin
                n_acc[c] = {1'b0, {(pmg_pkg::OUT_W-1){1'b1}}};
                n_flag   = 1'b1;
            end else if (w_dif[c][pmg_pkg::DIF_W-1]
                         && !(&w_dif[c][pmg_pkg::DIF_W-2:pmg_pkg::OUT_W-1])) begin
                n_acc[c] = {1'b1, {(pmg_pkg::OUT_W-1){1'b0}}};
                n_flag   = 1'b1;
            end else begin
                n_acc[c] = w_dif[c][pmg_pkg::OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < 3; c++) begin
                if (w_mode) begin
                    r_out[c]   <= n_acc[c];
                    r_out[3+c] <= '0;
                end else begin
                    r_out[c]   <= w_vel[c];
                    r_out[3+c] <= n_acc[c];
                end
            end
            r_sat  <= n_flag;
            r_last <= w_last;
        end
    end

    assign o_out.valid     = r_vld[pmg_pkg::LAT_ALL-1];
    assign o_out.out_a     = r_out[0];
    assign o_out.out_b     = r_out[1];
    assign o_out.out_c     = r_out[2];
    assign o_out.out_d     = r_out[3];
    assign o_out.out_e     = r_out[4];
    assign o_out.out_f     = r_out[5];
    assign o_out.saturated = r_sat;
    assign o_out.last_out  = r_last;

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("valid chain moved during stall");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid right after reset");

    a_mu_write_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_cfg_we) |-> $stable(r_mu))
        else $error("mu changed without a write");
`endif

endmodule

`default_nettype wire

// ===== tb/pmg_scoreboard.sv =====
`default_nettype none

module pmg_scoreboard (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    pmg_in_if                             i_in,
    pmg_out_if                            i_out,
    input  wire logic                     i_cfg_we,
    input  wire logic [pmg_pkg::MU_W-1:0] i_cfg_wdata,
    output int                            o_errors,
    output int                            o_pending
);
    import pmg_pkg::*;

    typedef logic [255:0]        ubig_t;
    typedef logic signed [259:0] sbig_t;

    typedef struct {
        logic [OUT_W-1:0] f[6];
        logic             saturated;
        logic             last_out;
    } deriv_t;

    deriv_t           deriv_q[$];
    logic [MU_W-1:0]  mu;

    function automatic ubig_t root_floor(ubig_t x);
        ubig_t acc, cand;
        acc = '0;
        for (int i = 90; i >= 0; i--) begin
            cand = acc | (ubig_t'(1) << i);
            if (cand * cand <= x) acc = cand;
        end
        return acc;
    endfunction

    // mu*v/|v|^3 per component, 2^-52 units; returns 0 for a zero vector
    function automatic bit pull_toward(input t_vec v[3], input logic [MU_W-1:0] m,
                                       output sbig_t q[3]);
        ubig_t mag[3];
        ubig_t s, t, den, quo;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = ubig_t'(v[i] < 0 ? -v[i] : v[i]);
            s += mag[i] * mag[i];
            q[i] = '0;
        end
        if (s == 0) return 0;
        t = root_floor(s << 32);
        den = s * t;
        for (int i = 0; i < 3; i++) begin
            quo = ((ubig_t'(m) * mag[i]) << 68) / den;
            q[i] = v[i] < 0 ? -sbig_t'({4'b0, quo}) : sbig_t'({4'b0, quo});
        end
        return 1;
    endfunction

    function automatic deriv_t predict_deriv(input logic md, input t_vec bv[3],
                                             input t_vec pv[3], input logic [47:0] vv[3],
                                             input logic lst);
        deriv_t r;
        t_vec   dv[3];
        sbig_t  qd[3], qb[3], a;
        logic [OUT_W-1:0] acc[3];
        bit     ok;
        r.saturated = 0;
        for (int i = 0; i < 3; i++) dv[i] = bv[i] - pv[i];
        ok = pull_toward(dv, mu, qd);
        void'(pull_toward(bv, mu, qb));
        for (int i = 0; i < 3; i++) begin
            a = qd[i] - qb[i];
            if (!ok) a = '0;
            if (a > sbig_t'(48'h7FFF_FFFF_FFFF)) begin
                a = sbig_t'(48'h7FFF_FFFF_FFFF);
                r.saturated = 1;
            end else if (a < -sbig_t'(49'h0_8000_0000_0000)) begin
                a = -sbig_t'(49'h0_8000_0000_0000);
                r.saturated = 1;
            end
            acc[i] = a[OUT_W-1:0];
        end
        if (!ok) r.saturated = 1;
        for (int i = 0; i < 3; i++) begin
            r.f[i]     = md ? acc[i] : vv[i];
            r.f[3 + i] = md ? '0 : acc[i];
        end
        r.last_out = lst;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [OUT_W-1:0] exp_v,
                                 input logic [OUT_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            o_errors++;
        end
    endtask

    initial o_errors = 0;
    assign o_pending = deriv_q.size();

    always @(posedge i_clk) begin
        t_vec        bv[3], pv[3];
        logic [47:0] vv[3];
        deriv_t      e;
        string       names[6];
        logic [OUT_W-1:0] act[6];
        names = '{"out_a", "out_b", "out_c", "out_d", "out_e", "out_f"};
        if (!i_rst_n) begin
            mu <= MU_RESET;
        end else begin
            if (i_cfg_we) mu <= i_cfg_wdata;
            if (i_in.valid && i_in.ready) begin
                bv = '{t_vec'(i_in.body_x), t_vec'(i_in.body_y), t_vec'(i_in.body_z)};
                pv = '{t_vec'(i_in.sat_px), t_vec'(i_in.sat_py), t_vec'(i_in.sat_pz)};
                vv = '{i_in.sat_vx, i_in.sat_vy, i_in.sat_vz};
                deriv_q.push_back(predict_deriv(i_in.mode, bv, pv, vv, i_in.last_in));
            end
            if (i_out.valid && i_out.ready) begin
                if (deriv_q.size() == 0) begin
                    $error("result with no request outstanding");
                    o_errors++;
                end else begin
                    e = deriv_q.pop_front();
                    act = '{i_out.out_a, i_out.out_b, i_out.out_c,
                            i_out.out_d, i_out.out_e, i_out.out_f};
                    for (int i = 0; i < 6; i++) compare_field(names[i], e.f[i], act[i]);
                    compare_field("saturated", 48'(e.saturated), 48'(i_out.saturated));
                    compare_field("last_out", 48'(e.last_out), 48'(i_out.last_out));
                end
            end
        end
    end
endmodule

`default_nettype wire

// ===== tb/tb_point_mass_gravity_derivative_top.sv =====
`default_nettype none

module tb_point_mass_gravity_derivative_top;
    import pmg_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 200;
    localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG_MAX = 48'h8000_0000_0000;

    typedef struct {
        logic        mode;
        logic [47:0] b[3];
        logic [47:0] p[3];
        logic [47:0] v[3];
        logic        last;
    } sc_state_t;

    logic            i_clk = 0;
    logic            i_rst_n = 0;
    logic            cfg_we = 0;
    logic [MU_W-1:0] cfg_wdata = '0;
    int              errors, pending;
    bit              no_gaps = 0;
    bit              hold_req = 0;
    int              idle_cycles = 0;

    pmg_in_if  in_ch ();
    pmg_out_if out_ch ();

    point_mass_gravity_derivative_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata)
    );

    pmg_scoreboard scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata), .o_errors(errors), .o_pending(pending)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0; in_ch.mode = 0; in_ch.last_in = 0;
        in_ch.body_x = '0; in_ch.body_y = '0; in_ch.body_z = '0;
        in_ch.sat_px = '0; in_ch.sat_py = '0; in_ch.sat_pz = '0;
        in_ch.sat_vx = '0; in_ch.sat_vy = '0; in_ch.sat_vz = '0;
        out_ch.ready = 0;
    end

    // receiver: random stall per result, one long hold-off on request
    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 0;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end else begin
                w = no_gaps ? 0 : $urandom_range(0, 11);
                if (w > 0) begin
                    out_ch.ready <= 0;
                    repeat (w) @(posedge i_clk);
                end
            end
            out_ch.ready <= 1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [47:0] rnd48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic logic [47:0] rnd_scaled();
        logic [47:0] x;
        x = rnd48() >> $urandom_range(0, 47);
        return $urandom_range(0, 1) ? -x : x;
    endfunction

    function automatic logic [47:0] pick_edge();
        case ($urandom_range(0, 4))
            0: return POS_MAX;
            1: return NEG_MAX;
            2: return '0;
            3: return 48'd1;
            default: return '1;
        endcase
    endfunction

    function automatic sc_state_t rand_state();
        sc_state_t s;
        int        kind;
        kind = $urandom_range(0, 9);
        s.mode = 1'($urandom_range(0, 1));
        s.last = 1'($urandom_range(0, 1));
        for (int i = 0; i < 3; i++) begin
            s.v[i] = rnd48();
            case (kind)
                0, 1, 2, 3, 4, 5: begin
                    // spacecraft near the body, distance swept over many scales
                    s.b[i] = rnd48() >>> $urandom_range(1, 20);
                    s.p[i] = s.b[i] + (rnd_scaled() >>> 4);
                end
                6: begin
                    s.b[i] = rnd48();
                    s.p[i] = rnd48();
                end
                7: begin
                    s.b[i] = rnd48();
                    s.p[i] = s.b[i];
                end
                8: begin
                    s.b[i] = '0;
                    s.p[i] = rnd_scaled();
                end
                default: begin
                    s.b[i] = pick_edge();
                    s.p[i] = pick_edge();
                    s.v[i] = pick_edge();
                end
            endcase
        end
        return s;
    endfunction

    task automatic send_state(input sc_state_t s);
        int w;
        w = no_gaps ? 0 : $urandom_range(0, 11);
        if (w > 0) begin
            in_ch.valid <= 0;
            repeat (w) @(posedge i_clk);
        end
        in_ch.mode <= s.mode;
        in_ch.last_in <= s.last;
        in_ch.body_x <= s.b[0]; in_ch.body_y <= s.b[1]; in_ch.body_z <= s.b[2];
        in_ch.sat_px <= s.p[0]; in_ch.sat_py <= s.p[1]; in_ch.sat_pz <= s.p[2];
        in_ch.sat_vx <= s.v[0]; in_ch.sat_vy <= s.v[1]; in_ch.sat_vz <= s.v[2];
        in_ch.valid <= 1;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_mu(input logic [MU_W-1:0] val);
        wait_drained();
        cfg_wdata <= val;
        cfg_we <= 1;
        @(posedge i_clk);
        cfg_we <= 0;
    endtask

    task automatic run_random(input int n);
        for (int k = 0; k < n; k++) begin
            no_gaps = (k % 100) >= 80;
            send_state(rand_state());
        end
        no_gaps = 0;
    endtask

    task automatic run_directed();
        sc_state_t s;
        logic [47:0] edges[4];
        edges = '{POS_MAX, NEG_MAX, '0, '1};
        foreach (edges[e]) begin
            for (int md = 0; md < 2; md++) begin
                s.mode = 1'(md);
                s.last = e[0];
                for (int i = 0; i < 3; i++) begin
                    s.b[i] = edges[e];
                    s.p[i] = edges[(e + 1) % 4];
                    s.v[i] = edges[(e + i) % 4];
                end
                send_state(s);
            end
        end
        // zero distance, zero body vector, both zero, unit offsets, extreme opposite positions
        s.mode = 0; s.last = 1;
        for (int i = 0; i < 3; i++) begin s.b[i] = 48'd5000; s.p[i] = 48'd5000; end
        send_state(s);
        s.mode = 1;
        for (int i = 0; i < 3; i++) begin s.b[i] = '0; s.p[i] = 48'd7000 << i; end
        send_state(s);
        for (int i = 0; i < 3; i++) begin s.b[i] = '0; s.p[i] = '0; end
        send_state(s);
        s.p[0] = 48'd1; s.p[1] = '0; s.p[2] = '1;
        send_state(s);
        for (int i = 0; i < 3; i++) begin s.b[i] = NEG_MAX; s.p[i] = POS_MAX; end
        send_state(s);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        run_directed();
        run_random(250);
        write_mu('0);
        run_directed();
        run_random(150);
        write_mu('1);
        run_directed();
        hold_req = 1;
        run_random(300);
        wait_drained();
        write_mu(rnd48());
        run_random(250);
        write_mu(MU_RESET);
        run_random(250);
        wait_drained();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

`default_nettype wire
